[design/vdi_pkg.sv]
// Shared types, constants and hash helpers for the vertex dedup indexer.
package vdi_pkg;

   // Default sizes of the vertex store and the bucket table
   localparam int TABLE_DEPTH_DEF  = 4096;
   localparam int BUCKET_COUNT_DEF = 8192;

   // Result index width and coordinate width
   localparam int RSP_INDEX_W = 12;
   localparam int COORD_W     = 32;

   // Vertices per triangle
   localparam int VERTS_PER_TRI = 3;

   // Queue between front and back
   localparam int FIFO_DEPTH = 8;

   // Mesh generation tag kept with every bucket entry
   localparam int EPOCH_W = 8;

   // Hash constants
   localparam logic [31:0] HASH_SEED = 32'h811C_9DC5;
   localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

   // Coordinate triple as stored and compared
   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
   } key_type;

   // Per-item mesh control flags
   typedef struct packed {
      logic start_new_mesh;
      logic end_of_mesh;
   } mesh_flags_type;

   // Status from the back engine to the top level
   typedef struct packed {
      logic pop;
      logic clearing;
   } back_status_type;

   // Fold -0 onto +0
   function automatic logic [31:0] canon_zero(input logic [31:0] v);
      return (v[30:0] == 31'd0) ? 32'd0 : v;
   endfunction

   // Xor-shift step that follows each hash multiply
   function automatic logic [31:0] hash_mix(input logic [31:0] p);
      return p ^ (p >> 15);
   endfunction

endpackage

[design/vdi_front.sv]
// Front end: takes vertices, folds signed zeros and computes the home bucket.
module vdi_front #(
   parameter int  BUCKET_COUNT = vdi_pkg::BUCKET_COUNT_DEF,
   localparam int BW           = $clog2(BUCKET_COUNT)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  vdi_pkg::mesh_flags_type in_flags,
   input  vdi_pkg::key_type        in_key,
   output logic                    push,
   output vdi_pkg::mesh_flags_type out_flags,
   output vdi_pkg::key_type        out_key,
   output logic [BW-1:0]           out_home
);
   import vdi_pkg::*;

   localparam int          STAGES  = 5;
   localparam logic [63:0] RECIP64 = (64'd1 << 32) / 64'(BUCKET_COUNT);
   localparam logic [31:0] RECIP   = RECIP64[31:0];
   localparam logic [31:0] BCNT    = 32'(BUCKET_COUNT);

   logic           [STAGES-1:0] valid_ff;
   key_type                     key_ff   [STAGES];
   mesh_flags_type              flags_ff [STAGES];

   key_type     key_in;
   logic [31:0] p1_in, p1_ff;
   logic [31:0] p2_in, p2_ff;
   logic [31:0] p3_in, p3_ff;
   logic [31:0] h4_in, h4_ff, h5_ff;
   logic [63:0] qprod;
   logic [31:0] q4_ff;
   logic [31:0] qb_in, qb5_ff;
   logic [31:0] rem;
   logic [31:0] home_full;

   // Fold signed zeros at the input
   always_comb begin
      key_in.x = canon_zero(in_key.x);
      key_in.y = canon_zero(in_key.y);
      key_in.z = canon_zero(in_key.z);
   end

   // Hash rounds, one multiply per stage
   assign p1_in = (HASH_SEED ^ key_in.x) * HASH_MULT;
   assign p2_in = (hash_mix(p1_ff) ^ key_ff[0].y) * HASH_MULT;
   assign p3_in = (hash_mix(p2_ff) ^ key_ff[1].z) * HASH_MULT;

   // Bucket reduction: reciprocal estimate, back-multiply, one correction
   assign h4_in = hash_mix(p3_ff);
   assign qprod = {32'd0, h4_in} * {32'd0, RECIP};
   assign qb_in = q4_ff * BCNT;
   assign rem   = h5_ff - qb5_ff;
   assign home_full = (rem >= BCNT) ? (rem - BCNT) : rem;

   // Advance the valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[STAGES-2:0], accept};
      end
   end

   // Advance the payload
   always_ff @(posedge clock) begin
      key_ff[0]   <= key_in;
      flags_ff[0] <= in_flags;
      for (int i = 1; i < STAGES; i++) begin
         key_ff[i]   <= key_ff[i-1];
         flags_ff[i] <= flags_ff[i-1];
      end
      p1_ff  <= p1_in;
      p2_ff  <= p2_in;
      p3_ff  <= p3_in;
      h4_ff  <= h4_in;
      q4_ff  <= qprod[63:32];
      h5_ff  <= h4_ff;
      qb5_ff <= qb_in;
   end

   assign push      = valid_ff[STAGES-1];
   assign out_flags = flags_ff[STAGES-1];
   assign out_key   = key_ff[STAGES-1];
   assign out_home  = home_full[BW-1:0];

endmodule

[design/vdi_fifo.sv]
// Short queue of hashed vertices between the front end and the probe engine.
module vdi_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = vdi_pkg::FIFO_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             head_valid
);
   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   // Wrap pointers at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed entries
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data  = mem_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);

endmodule

[design/vdi_back.sv]
// Probe engine: bucket table walk, key compare, insert and result formation.
module vdi_back #(
   parameter int  TABLE_DEPTH  = vdi_pkg::TABLE_DEPTH_DEF,
   parameter int  BUCKET_COUNT = vdi_pkg::BUCKET_COUNT_DEF,
   localparam int BW           = $clog2(BUCKET_COUNT)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               head_valid,
   input  vdi_pkg::mesh_flags_type            head_flags,
   input  vdi_pkg::key_type                   head_key,
   input  logic [BW-1:0]                      head_home,
   output vdi_pkg::back_status_type           status,
   output logic                               rsp_valid,
   output logic [vdi_pkg::RSP_INDEX_W-1:0]    rsp_vertex_index,
   output logic                               rsp_is_new,
   output logic                               rsp_table_full,
   output logic                               rsp_count_error
);
   import vdi_pkg::*;

   localparam int IW      = $clog2(TABLE_DEPTH);
   localparam int CW      = $clog2(TABLE_DEPTH + 1);
   localparam int ENTRY_W = 1 + EPOCH_W + IW;
   localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_BCHK  = 4'b0100,
      ST_CCHK  = 4'b1000
   } back_state_type;

   // Bucket entry: valid, epoch tag, vertex index
   logic [ENTRY_W-1:0] bucket_mem [BUCKET_COUNT];
   key_type            coord_mem  [TABLE_DEPTH];

   back_state_type     state_ff, state_in;
   logic [BW-1:0]      clr_addr_ff, clr_addr_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [1:0]         phase_ff, phase_in;
   logic [BW-1:0]      slot_ff, slot_in;
   logic [BW-1:0]      probe_ff, probe_in;
   logic [IW-1:0]      cand_ff, cand_in;
   mesh_flags_type     item_flags_ff, item_flags_in;
   key_type            item_key_ff, item_key_in;
   logic [ENTRY_W-1:0] bkt_rd_ff;
   key_type            crd_rd_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic                   rsp_new_ff, rsp_new_in;
   logic                   rsp_full_ff, rsp_full_in;
   logic                   rsp_cerr_ff, rsp_cerr_in;

   logic [BW-1:0]      bkt_raddr;
   logic               bkt_we;
   logic [BW-1:0]      bkt_waddr;
   logic [ENTRY_W-1:0] bkt_wdata;
   logic [IW-1:0]      crd_raddr;
   logic               crd_we;

   logic               pop;
   logic               e_valid;
   logic [IW-1:0]      e_index;
   logic [BW-1:0]      slot_nx;
   logic               done;
   logic [IW-1:0]      res_index;
   logic               res_new;
   logic               res_full;
   logic [1:0]         phase_nx;

   // Decode the bucket entry read last cycle
   assign e_valid = bkt_rd_ff[ENTRY_W-1] && (bkt_rd_ff[IW +: EPOCH_W] == epoch_ff);
   assign e_index = bkt_rd_ff[IW-1:0];
   assign slot_nx = (slot_ff == BW'(BUCKET_COUNT - 1)) ? '0 : slot_ff + 1'b1;

   // Triangle phase after this vertex
   assign phase_nx = (phase_ff == 2'(VERTS_PER_TRI - 1)) ? 2'd0 : phase_ff + 2'd1;

   // Sequence clearing, probing and insertion
   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      epoch_in      = epoch_ff;
      count_in      = count_ff;
      phase_in      = phase_ff;
      slot_in       = slot_ff;
      probe_in      = probe_ff;
      cand_in       = cand_ff;
      item_flags_in = item_flags_ff;
      item_key_in   = item_key_ff;
      bkt_raddr     = slot_ff;
      bkt_we        = 1'b0;
      bkt_waddr     = slot_ff;
      bkt_wdata     = '0;
      crd_raddr     = e_index;
      crd_we        = 1'b0;
      pop           = 1'b0;
      done          = 1'b0;
      res_index     = '0;
      res_new       = 1'b0;
      res_full      = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            // Sweep every bucket to invalid
            bkt_we    = 1'b1;
            bkt_waddr = clr_addr_ff;
            if (clr_addr_ff == BW'(BUCKET_COUNT - 1)) begin
               clr_addr_in = '0;
               epoch_in    = '0;
               state_in    = ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            bkt_raddr = head_home;
            if (head_valid) begin
               if (head_flags.start_new_mesh && (epoch_ff == EPOCH_MAX)) begin
                  // Epoch tags are used up: wipe the table first
                  state_in = ST_CLEAR;
               end else begin
                  pop           = 1'b1;
                  item_flags_in = head_flags;
                  item_key_in   = head_key;
                  slot_in       = head_home;
                  probe_in      = '0;
                  if (head_flags.start_new_mesh) begin
                     epoch_in = epoch_ff + 1'b1;
                     count_in = '0;
                     phase_in = '0;
                  end
                  state_in = ST_BCHK;
               end
            end
         end
         ST_BCHK: begin
            if (e_valid) begin
               // Occupied bucket: fetch its stored triple
               cand_in  = e_index;
               state_in = ST_CCHK;
            end else begin
               done = 1'b1;
               if (count_ff < CW'(TABLE_DEPTH)) begin
                  // Free bucket: append the triple
                  bkt_we    = 1'b1;
                  bkt_wdata = {1'b1, epoch_ff, count_ff[IW-1:0]};
                  crd_we    = 1'b1;
                  res_index = count_ff[IW-1:0];
                  res_new   = 1'b1;
                  count_in  = count_ff + 1'b1;
               end else begin
                  res_full = 1'b1;
               end
            end
         end
         ST_CCHK: begin
            if (crd_rd_ff == item_key_ff) begin
               done      = 1'b1;
               res_index = cand_ff;
            end else if (probe_ff == BW'(BUCKET_COUNT - 1)) begin
               // Every bucket visited, none free
               done     = 1'b1;
               res_full = 1'b1;
            end else begin
               slot_in   = slot_nx;
               probe_in  = probe_ff + 1'b1;
               bkt_raddr = slot_nx;
               state_in  = ST_BCHK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Form the result and update the triangle phase
      rsp_valid_in = done;
      rsp_index_in = rsp_index_ff;
      rsp_new_in   = rsp_new_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_cerr_in  = rsp_cerr_ff;
      if (done) begin
         state_in     = ST_IDLE;
         rsp_index_in = RSP_INDEX_W'(res_index);
         rsp_new_in   = res_new;
         rsp_full_in  = res_full;
         rsp_cerr_in  = item_flags_ff.end_of_mesh && (phase_nx != 2'd0);
         phase_in     = item_flags_ff.end_of_mesh ? 2'd0 : phase_nx;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         epoch_ff     <= '0;
         count_ff     <= '0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         epoch_ff     <= epoch_in;
         count_ff     <= count_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      slot_ff       <= slot_in;
      probe_ff      <= probe_in;
      cand_ff       <= cand_in;
      item_flags_ff <= item_flags_in;
      item_key_ff   <= item_key_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_new_ff    <= rsp_new_in;
      rsp_full_ff   <= rsp_full_in;
      rsp_cerr_ff   <= rsp_cerr_in;
   end

   // Bucket table memory
   always_ff @(posedge clock) begin
      if (bkt_we) begin
         bucket_mem[bkt_waddr] <= bkt_wdata;
      end
      bkt_rd_ff <= bucket_mem[bkt_raddr];
   end

   // Coordinate store memory
   always_ff @(posedge clock) begin
      if (crd_we) begin
         coord_mem[count_ff[IW-1:0]] <= item_key_ff;
      end
      crd_rd_ff <= coord_mem[crd_raddr];
   end

   assign status.pop      = pop;
   assign status.clearing = (state_ff == ST_CLEAR);

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vertex_index = rsp_index_ff;
   assign rsp_is_new       = rsp_new_ff;
   assign rsp_table_full   = rsp_full_ff;
   assign rsp_count_error  = rsp_cerr_ff;

endmodule

[design/vertex_dedup_indexer_top.sv]
// Top level of the vertex dedup indexer: front end, queue and probe engine.
//
// One result per vertex, in input order, shown for one cycle with rsp_valid;
// the receiver cannot stall it. A vertex is taken when start is high and busy
// low. The registered hash front end takes one vertex per cycle while busy is
// low; an 8-entry queue feeds the probe engine, which sets the rate and takes
// a new vertex only when done with the last: an idle step and a bucket check,
// a coordinate check if that bucket is occupied, and for every further bucket
// probed another bucket read and coordinate read. After reset busy stays high
// while the bucket table is swept clear; the 256th start of a new mesh, and
// every 255th after it, runs the same sweep before that vertex is handled.
module vertex_dedup_indexer_top #(
   parameter int TABLE_DEPTH  = vdi_pkg::TABLE_DEPTH_DEF,
   parameter int BUCKET_COUNT = vdi_pkg::BUCKET_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_start_new_mesh,
   input  logic [vdi_pkg::COORD_W-1:0]     req_coord_x,
   input  logic [vdi_pkg::COORD_W-1:0]     req_coord_y,
   input  logic [vdi_pkg::COORD_W-1:0]     req_coord_z,
   input  logic                            req_end_of_mesh,
   output logic                            rsp_valid,
   output logic [vdi_pkg::RSP_INDEX_W-1:0] rsp_vertex_index,
   output logic                            rsp_is_new,
   output logic                            rsp_table_full,
   output logic                            rsp_count_error
);
   import vdi_pkg::*;

   localparam int BW     = $clog2(BUCKET_COUNT);
   localparam int QW     = $bits(mesh_flags_type) + $bits(key_type) + BW;
   localparam int OCC_W  = $clog2(FIFO_DEPTH + 1);

   logic             accept;
   mesh_flags_type   in_flags;
   key_type          in_key;
   logic             push;
   mesh_flags_type   f_flags;
   key_type          f_key;
   logic [BW-1:0]    f_home;
   logic [QW-1:0]    head_data;
   logic             head_valid;
   mesh_flags_type   head_flags;
   key_type          head_key;
   logic [BW-1:0]    head_home;
   back_status_type  status;
   logic [OCC_W-1:0] occ_ff, occ_in;

   assign in_flags.start_new_mesh = req_start_new_mesh;
   assign in_flags.end_of_mesh    = req_end_of_mesh;
   assign in_key.x                = req_coord_x;
   assign in_key.y                = req_coord_y;
   assign in_key.z                = req_coord_z;

   // Hold off new vertices while clearing or when the queue has no free slot
   assign busy   = status.clearing || (occ_ff == OCC_W'(FIFO_DEPTH));
   assign accept = start && !busy;

   // Count vertices in the front end and queue
   assign occ_in = occ_ff + OCC_W'(accept) - OCC_W'(status.pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   vdi_front #(
      .BUCKET_COUNT(BUCKET_COUNT)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .in_flags (in_flags),
      .in_key   (in_key),
      .push     (push),
      .out_flags(f_flags),
      .out_key  (f_key),
      .out_home (f_home)
   );

   vdi_fifo #(
      .WIDTH(QW),
      .DEPTH(FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({f_flags, f_key, f_home}),
      .pop       (status.pop),
      .head_data (head_data),
      .head_valid(head_valid)
   );

   assign {head_flags, head_key, head_home} = head_data;

   vdi_back #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .BUCKET_COUNT(BUCKET_COUNT)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_flags      (head_flags),
      .head_key        (head_key),
      .head_home       (head_home),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_vertex_index(rsp_vertex_index),
      .rsp_is_new      (rsp_is_new),
      .rsp_table_full  (rsp_table_full),
      .rsp_count_error (rsp_count_error)
   );

endmodule

[design/vdi_checker.sv]
// Port-level checks for the vertex dedup indexer, bound to the top level.
module vdi_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            rsp_valid,
   input logic [vdi_pkg::RSP_INDEX_W-1:0] rsp_vertex_index,
   input logic                            rsp_is_new,
   input logic                            rsp_table_full
);
   import vdi_pkg::*;

   logic [4:0] outstanding_ff, outstanding_in;

   // Track transactions taken but not yet answered
   assign outstanding_in = outstanding_ff + 5'(start && !busy) - 5'(rsp_valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   // A full table answers with index zero and no new vertex
   a_full_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_table_full) |-> ((rsp_vertex_index == '0) && !rsp_is_new))
      else $error("table_full result with nonzero index or new flag");

   // Every result answers an earlier transaction
   a_no_stray: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (outstanding_ff != 5'd0))
      else $error("result without an outstanding transaction");

   // The table sweep after reset keeps the block busy
   a_busy_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> busy)
      else $error("not busy right after reset");

   // No result leaves right after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result right after reset");

endmodule

bind vertex_dedup_indexer_top vdi_checker u_vdi_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_vertex_index(rsp_vertex_index),
   .rsp_is_new      (rsp_is_new),
   .rsp_table_full  (rsp_table_full)
);
